/* rtl/base64_stream_encoder_top_macros.svh */
// ----------------------------------------------------------------------------
// Base64 stream encoder - assertion macros
// Clocked assertion helpers shared by the encoder modules.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every edge out of reset
`define B64E_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b64enc assertion failed");
// cond must never be seen out of reset
`define B64E_NEVER(label, clk, rst_n, cond) \
  `B64E_ASSERT(label, clk, rst_n, !(cond))
`else
`define B64E_ASSERT(label, clk, rst_n, prop)
`define B64E_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* rtl/b64enc_pkg.sv */
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the sextet alphabet of the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned MAX_CHARS      = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'd61;  // '='
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'd43;  // '+'
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'd47;  // '/'
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'd65;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'd71;  // 'a' minus 26
  localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'd4;   // 52 minus '0'

  // One input byte: up to four characters, emitted slot 0 upwards
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [1:0]                       last_idx;
    logic                             eom;
  } b64enc_cmd_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 6'd26) begin
      c = CHAR_UPPER + {1'b0, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - CHAR_DIGIT;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

/* rtl/b64enc_front.sv */
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes, tracks the group phase and builds character words.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_macros.svh"

module b64enc_front
  import b64enc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_eom_i,
  output logic        push_o,
  output b64enc_cmd_t cmd_o,
  input  logic        full_i
);

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  logic [1:0] phase_q, phase_d, phase_nx;
  logic [5:0] left_q, left_d, left_nx;
  logic       pad_q;
  logic       accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    cmd_o        = '0;
    cmd_o.eom    = in_eom_i;
    phase_nx     = PH_FIRST;
    left_nx      = '0;
    unique case (phase_q)
      PH_FIRST: begin
        cmd_o.chars[0] = sextet_char(in_byte_i[7:2]);
        left_nx        = {in_byte_i[1:0], 4'b0};
        phase_nx       = PH_SECOND;
      end
      PH_SECOND: begin
        cmd_o.chars[0] = sextet_char(left_q | {2'b0, in_byte_i[7:4]});
        left_nx        = {in_byte_i[3:0], 2'b0};
        phase_nx       = PH_THIRD;
      end
      default: begin
        // third byte (and the unused phase code) closes the group
        cmd_o.chars[0] = sextet_char(left_q | {4'b0, in_byte_i[7:6]});
        cmd_o.chars[1] = sextet_char(in_byte_i[5:0]);
        cmd_o.last_idx = 2'd1;
      end
    endcase

    // flush leftover bits on a partial final group, with '=' padding when pad_enable is set
    if (in_eom_i && phase_nx != PH_FIRST) begin
      cmd_o.chars[1] = sextet_char(left_nx);
      cmd_o.chars[2] = CHAR_PAD;
      cmd_o.chars[3] = CHAR_PAD;
      if (!pad_q) begin
        cmd_o.last_idx = 2'd1;
      end else if (phase_nx == PH_SECOND) begin
        cmd_o.last_idx = 2'd3;
      end else begin
        cmd_o.last_idx = 2'd2;
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    if (accept) begin
      phase_d = in_eom_i ? PH_FIRST : phase_nx;
      left_d  = in_eom_i ? 6'd0 : left_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      left_q  <= '0;
      pad_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      if (cfg_we_i) begin
        pad_q <= cfg_wdata_i;
      end
    end
  end

  `B64E_NEVER(a_phase_legal, clk_i, rst_ni, phase_q == 2'd3)

endmodule

/* rtl/b64enc_queue.sv */
// ----------------------------------------------------------------------------
// b64enc_queue
// Short FIFO of character words between the front and the back.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_macros.svh"

module b64enc_queue
  import b64enc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  b64enc_cmd_t push_cmd_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output b64enc_cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  b64enc_cmd_t       mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  `B64E_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= Full)
  `B64E_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o)

endmodule

/* rtl/b64enc_back.sv */
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the characters of the head word and drives the output register.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_macros.svh"

module b64enc_back
  import b64enc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  b64enc_cmd_t       q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o
);

  logic [1:0]        idx_q, idx_d;
  logic              vld_q, vld_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              load, at_end;

  assign load    = !vld_q || out_ready_i;
  assign at_end  = (idx_q == q_head_i.last_idx);
  assign q_pop_o = load && q_valid_i && at_end;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    char_d = char_q;
    last_d = last_q;
    if (load) begin
      vld_d  = q_valid_i;
      char_d = q_head_i.chars[idx_q];
      last_d = q_head_i.eom && at_end;
      if (q_valid_i) begin
        idx_d = at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  `B64E_ASSERT(a_idx_in_word, clk_i, rst_ni, !q_valid_i || idx_q <= q_head_i.last_idx)
  `B64E_ASSERT(a_idx_needs_word, clk_i, rst_ni, idx_q == 2'd0 || q_valid_i)

endmodule

/* rtl/base64_stream_encoder_top.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Byte stream in, Base64 character stream out (standard alphabet).
// ----------------------------------------------------------------------------
// Usage:
//  - Slave side takes one message byte per word in tdata; tlast marks the
//    final byte of a message. Messages hold at least one byte.
//  - Master side gives one ASCII character per word in tdata[6:0]; tlast is
//    set on the final character of each encoded message.
//  - cfg_we_i/cfg_wdata_i write pad_enable (reset 1), sampled on the last
//    byte of a message; write only while the block is idle.
//  - Each byte yields one or two characters, up to four on the last byte
//    (flush plus '=' padding). The output register sends one character per
//    cycle while m_axis_tready_i is high.
//  - With the back free, the first character of a byte enters the queue at
//    the edge that takes the byte and then loads into the output register.
//  - Stalls: the output register and the word queue absorb back-pressure;
//    tready on the slave side drops only once the queue is full.
//  - Reset clears group phase, leftover bits and the queue; pad_enable
//    returns to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top
  import b64enc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration: pad_enable
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // byte input
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_message
  // character output
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast_o    // last_char
);

  b64enc_cmd_t       push_cmd, head_cmd;
  logic              push, full, pop, q_valid;
  logic [CHAR_W-1:0] out_char;

  // front: phase tracking and character lookup per byte
  b64enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_eom_i    (s_axis_tlast_i),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .full_i      (full)
  );

  // decouples byte intake from character emission
  b64enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  // back: one character per cycle into the output register while it is not stalled
  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

endmodule
